// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

  localparam int WORD_BITS            = 64;
  localparam int DEFAULT_BITMAP_WORDS = 64;
  localparam logic [6:0] WORDS_IN_USE_RESET = 7'd64;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // per-word summary from the shared evaluation unit
  typedef struct packed {
    logic       all_free;
    logic [6:0] tz;         // free bits from bit 0 upwards
    logic [6:0] lz;         // free bits from bit 63 downwards
    logic       inner_hit;
    logic [5:0] inner_pos;  // first start of a run that fits inside the word
  } word_eval_t;

endpackage

// ===== rtl/bfa_ram.sv =====
module bfa_ram import bfa_pkg::*; #(
  parameter int WIDTH = WORD_BITS,
  parameter int DEPTH = DEFAULT_BITMAP_WORDS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/bfa_word_eval.sv =====
module bfa_word_eval import bfa_pkg::*; (
  input  logic [WORD_BITS-1:0] word,
  input  logic [12:0]          count,
  output word_eval_t           ev
);

  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] pw [0:5];
  logic [WORD_BITS-1:0] acc;
  logic                 started;
  logic [6:0]           tz;
  logic [6:0]           lz;
  logic [5:0]           pos;

  assign free_bits = ~word;

  // pw[i] marks starts of free runs of length 2**i
  always_comb begin
    pw[0] = free_bits;
    for (int i = 1; i < 6; i++) begin
      pw[i] = pw[i-1] & (pw[i-1] >> (2 ** (i - 1)));
    end
  end

  // compose runs of exactly count bits from the power-of-two pieces
  // the first piece is taken as it is so a run may end on bit 63
  always_comb begin
    acc     = '1;
    started = 1'b0;
    for (int i = 0; i < 6; i++) begin
      if (count[i]) begin
        acc     = started ? (pw[i] & (acc >> (2 ** i))) : pw[i];
        started = 1'b1;
      end
    end
  end

  always_comb begin
    tz = 7'd64;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        tz = 7'(i);
      end
    end
  end

  always_comb begin
    lz = 7'd64;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (word[i]) begin
        lz = 7'(WORD_BITS - 1 - i);
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (acc[i]) begin
        pos = 6'(i);
      end
    end
  end

  assign ev.all_free  = (word == '0);
  assign ev.tz        = tz;
  assign ev.lz        = lz;
  assign ev.inner_hit = (count != 13'd0) && (count < 13'd64) && (acc != '0);
  assign ev.inner_pos = pos;

endmodule

// ===== rtl/bitmap_frame_allocator.sv =====
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall   | in_kind, in_start_frame, in_frame_count
// out     | out       | out_valid/out_stall | out_ok, out_frame_index, out_allocated_total
// cfg     | in        | cfg_we              | cfg_wdata (words in use)
//
// allocate: the scan reads one bitmap word per cycle until a run is found or the words run out,
// then each marked word is read and then written back, and the result is handed over
// free: each touched word is read and then written back, then the result is handed over
// the bitmap ram has separate read and write addresses; marking reads a word before writing it
// after reset a clearing pass writes all-ones to every word, with in_stall held high
// in_stall is high while an item is in work; a waiting result does not hold off the next beat
module bitmap_frame_allocator import bfa_pkg::*; #(
  parameter int BITMAP_WORDS = DEFAULT_BITMAP_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [11:0] in_start_frame,
  input  logic [12:0] in_frame_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_ok,
  output logic [11:0] out_frame_index,
  output logic [31:0] out_allocated_total,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int AW  = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int CW  = $clog2(BITMAP_WORDS + 1);
  localparam int NWW = (CW > 7) ? CW : 7;
  localparam int LW  = ((NWW + 6) > 13 ? (NWW + 6) : 13) + 1;

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_SCAN_RD = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_MARK_RD = 3'd4;
  localparam logic [2:0] S_MARK_WR = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [NWW-1:0] w_r, w_nxt;
  logic [6:0]     wiu_r, wiu_nxt;
  logic [31:0]    cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           kind_r, kind_nxt;
  logic [12:0]    count_r, count_nxt;
  logic [LW-1:0]  s_r, s_nxt;
  logic [LW-1:0]  e_last_r, e_last_nxt;
  logic [LW-1:0]  run_r, run_nxt;
  logic [LW-1:0]  rs_r, rs_nxt;
  logic           res_ok_r, res_ok_nxt;
  logic [11:0]    res_idx_r, res_idx_nxt;
  logic           out_ok_r, out_ok_nxt;
  logic [11:0]    out_idx_r, out_idx_nxt;
  logic [31:0]    out_tot_r, out_tot_nxt;

  logic                 ram_we;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;
  word_eval_t           ev;

  logic [NWW-1:0] nw;
  logic [NWW-1:0] w_inc;
  logic [LW-1:0]  cap;
  logic [LW-1:0]  base;
  logic [LW-1:0]  tzsum;
  logic           prefix_hit;
  logic           found;
  logic [LW-1:0]  scan_s;
  logic [LW-1:0]  free_s;
  logic [LW-1:0]  free_e;
  logic [LW-1:0]  free_ec;
  logic [32:0]    cnt_sum;
  logic [5:0]     lo_b;
  logic [5:0]     hi_b;
  logic [WORD_BITS-1:0] mask;
  logic           last_word;

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (BITMAP_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (w_r[AW-1:0]),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfa_word_eval u_eval (
    .word  (ram_rdata),
    .count (count_r),
    .ev    (ev)
  );

  assign nw    = (NWW'(wiu_r) > NWW'(BITMAP_WORDS)) ? NWW'(BITMAP_WORDS) : NWW'(wiu_r);
  assign w_inc = w_r + NWW'(1);
  assign cap   = LW'(nw) << 6;
  assign base  = LW'(w_r) << 6;

  // run carried in from earlier words plus free bits at the bottom of this one
  assign tzsum      = run_r + LW'(ev.tz);
  assign prefix_hit = (tzsum >= LW'(count_r));
  assign found      = prefix_hit || ev.inner_hit;
  assign scan_s     = prefix_hit ? ((run_r == '0) ? base : rs_r) : (base + LW'(ev.inner_pos));

  assign free_s  = LW'(in_start_frame);
  assign free_e  = free_s + LW'(in_frame_count);
  assign free_ec = (free_e > cap) ? cap : free_e;

  assign cnt_sum = {1'b0, cnt_r} + 33'(count_r);

  assign last_word = (LW'(w_r) == (e_last_r >> 6));
  assign lo_b = (LW'(w_r) == (s_r >> 6)) ? s_r[5:0] : 6'd0;
  assign hi_b = last_word ? e_last_r[5:0] : 6'd63;
  assign mask = ({WORD_BITS{1'b1}} << lo_b) & ({WORD_BITS{1'b1}} >> (6'd63 - hi_b));

  always_comb begin
    case (state_r)
      S_SCAN:  ram_raddr = w_inc[AW-1:0];
      default: ram_raddr = w_r[AW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    wiu_nxt       = cfg_we ? cfg_wdata : wiu_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    count_nxt     = count_r;
    s_nxt         = s_r;
    e_last_nxt    = e_last_r;
    run_nxt       = run_r;
    rs_nxt        = rs_r;
    res_ok_nxt    = res_ok_r;
    res_idx_nxt   = res_idx_r;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_tot_nxt   = out_tot_r;
    ram_we        = 1'b0;
    ram_wdata     = (kind_r == KIND_ALLOC) ? (ram_rdata | mask) : (ram_rdata & ~mask);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '1;
        if (w_r == NWW'(BITMAP_WORDS - 1)) begin
          w_nxt     = '0;
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_inc;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          count_nxt   = in_frame_count;
          res_idx_nxt = '0;
          if (in_kind == KIND_ALLOC) begin
            res_ok_nxt = 1'b0;
            if (in_frame_count == 13'd0 || nw == '0) begin
              state_nxt = S_DONE;
            end else begin
              w_nxt     = '0;
              run_nxt   = '0;
              rs_nxt    = '0;
              state_nxt = S_SCAN_RD;
            end
          end else begin
            res_ok_nxt = 1'b1;
            if (free_s >= free_ec) begin
              state_nxt = S_DONE;
            end else begin
              s_nxt      = free_s;
              e_last_nxt = free_ec - LW'(1);
              w_nxt      = NWW'(free_s >> 6);
              state_nxt  = S_MARK_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (found) begin
          if (scan_s == '0) begin
            // a run at frame zero would read as null
            state_nxt = S_DONE;
          end else begin
            s_nxt       = scan_s;
            e_last_nxt  = scan_s + LW'(count_r) - LW'(1);
            w_nxt       = NWW'(scan_s >> 6);
            res_ok_nxt  = 1'b1;
            res_idx_nxt = scan_s[11:0];
            cnt_nxt     = cnt_sum[32] ? '1 : cnt_sum[31:0];
            state_nxt   = S_MARK_RD;
          end
        end else if (w_inc >= nw) begin
          state_nxt = S_DONE;
        end else begin
          if (ev.all_free) begin
            if (run_r == '0) begin
              rs_nxt = base;
            end
            run_nxt = run_r + LW'(WORD_BITS);
          end else begin
            run_nxt = LW'(ev.lz);
            rs_nxt  = base + LW'(WORD_BITS) - LW'(ev.lz);
          end
          w_nxt = w_inc;
        end
      end
      S_MARK_RD: begin
        state_nxt = S_MARK_WR;
      end
      S_MARK_WR: begin
        ram_we = 1'b1;
        if (last_word) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt     = w_inc;
          state_nxt = S_MARK_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_idx_nxt   = res_idx_r;
          out_tot_nxt   = cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      wiu_r       <= WORDS_IN_USE_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      wiu_r       <= wiu_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    count_r   <= count_nxt;
    s_r       <= s_nxt;
    e_last_r  <= e_last_nxt;
    run_r     <= run_nxt;
    rs_r      <= rs_nxt;
    res_ok_r  <= res_ok_nxt;
    res_idx_r <= res_idx_nxt;
    out_ok_r  <= out_ok_nxt;
    out_idx_r <= out_idx_nxt;
    out_tot_r <= out_tot_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_ok              = out_ok_r;
  assign out_frame_index     = out_idx_r;
  assign out_allocated_total = out_tot_r;

  // an accepted beat always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted beat did not leave idle");

  // the allocation counter never goes down
  a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (cnt_r >= $past(cnt_r)))
    else $error("allocation counter decreased");

  // a successful allocate never hands out frame zero
  a_no_null_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MARK_WR && kind_r == KIND_ALLOC) |-> (s_r != '0 && res_ok_r))
    else $error("allocation marked a run at frame zero");

endmodule

// ===== tb/bfa_frame_checker.sv =====
module bfa_frame_checker import bfa_pkg::*; #(
  parameter int BITMAP_WORDS = DEFAULT_BITMAP_WORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_kind,
  input  logic [11:0] in_start_frame,
  input  logic [12:0] in_frame_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_ok,
  input  logic [11:0] out_frame_index,
  input  logic [31:0] out_allocated_total,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        ok;
    logic [11:0] frame_index;
    logic [31:0] total;
  } grant_t;

  logic [WORD_BITS-1:0] frame_map [BITMAP_WORDS];
  logic [31:0]          alloc_total;
  logic [6:0]           words_cfg;
  grant_t               grant_q [$];
  int                   beat_no;

  function automatic int live_words();
    return (int'(words_cfg) > BITMAP_WORDS) ? BITMAP_WORDS : int'(words_cfg);
  endfunction

  // frames at or past capacity are dropped, no wrap
  function automatic void set_frames(input int first, input int count, input logic used);
    int cap;
    int f;
    cap = live_words() * WORD_BITS;
    for (int k = 0; k < count; k++) begin
      f = first + k;
      if (f >= cap) break;
      frame_map[f / WORD_BITS][f % WORD_BITS] = used;
    end
  endfunction

  function automatic logic first_fit(input int count, output int start);
    int run;
    run = 0;
    start = 0;
    if (count == 0) return 1'b0;
    for (int w = 0; w < live_words(); w++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (frame_map[w][b]) run = 0;
        else run++;
        if (run >= count) begin
          start = w * WORD_BITS + b - (count - 1);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t apply_frame_op(input logic kind, input logic [11:0] first,
                                            input logic [12:0] count);
    grant_t      g;
    int          start;
    logic        hit;
    logic [32:0] sum;
    g = '0;
    if (kind == KIND_ALLOC) begin
      hit = first_fit(int'(count), start);
      // a run at frame zero would read as null, so it counts as a miss
      if (hit && start != 0) begin
        set_frames(start, int'(count), 1'b1);
        sum = {1'b0, alloc_total} + {20'd0, count};
        alloc_total = sum[32] ? 32'hffff_ffff : sum[31:0];
        g.ok = 1'b1;
        g.frame_index = start[11:0];
      end
    end else begin
      set_frames(int'(first), int'(count), 1'b0);
      g.ok = 1'b1;
    end
    g.total = alloc_total;
    return g;
  endfunction

  function automatic void report_miss(input string what, input grant_t want,
                                      input grant_t seen);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t beat %0d %s: exp ok=%0d idx=%0d tot=%0d, got ok=%0d idx=%0d tot=%0d",
               $time, beat_no, what, want.ok, want.frame_index, want.total,
               seen.ok, seen.frame_index, seen.total);
  endfunction

  always @(posedge clk) begin
    grant_t want;
    grant_t seen;
    if (!rst_n) begin
      for (int w = 0; w < BITMAP_WORDS; w++) frame_map[w] = '1;
      alloc_total = '0;
      words_cfg = WORDS_IN_USE_RESET;
      grant_q.delete();
      mismatches = 0;
      outstanding = 0;
      beat_no = 0;
    end else begin
      if (cfg_we) words_cfg = cfg_wdata;
      if (out_valid && !out_stall) begin
        seen.ok = out_ok;
        seen.frame_index = out_frame_index;
        seen.total = out_allocated_total;
        if (grant_q.size() == 0) begin
          report_miss("result with nothing pending", '0, seen);
        end else begin
          want = grant_q.pop_front();
          if (seen.ok !== want.ok || seen.frame_index !== want.frame_index ||
              seen.total !== want.total)
            report_miss("result mismatch", want, seen);
        end
        beat_no++;
      end
      if (in_valid && !in_stall)
        grant_q.push_back(apply_frame_op(in_kind, in_start_frame, in_frame_count));
      outstanding = grant_q.size();
    end
  end

endmodule

// ===== tb/tb_bitmap_frame_allocator.sv =====
module tb_bitmap_frame_allocator import bfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_WORDS = DEFAULT_BITMAP_WORDS;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_kind = KIND_ALLOC;
  logic [11:0] in_start_frame = '0;
  logic [12:0] in_frame_count = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;
  logic        in_stall;
  logic        out_valid;
  logic        out_ok;
  logic [11:0] out_frame_index;
  logic [31:0] out_allocated_total;
  int          mismatches;
  int          outstanding;

  int cur_words = 64;
  bit calm = 1'b0;
  bit hold_req = 1'b0;

  bitmap_frame_allocator #(.BITMAP_WORDS(FRAME_WORDS)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_start_frame      (in_start_frame),
    .in_frame_count      (in_frame_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_frame_index     (out_frame_index),
    .out_allocated_total (out_allocated_total),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  bfa_frame_checker #(.BITMAP_WORDS(FRAME_WORDS)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_start_frame      (in_start_frame),
    .in_frame_count      (in_frame_count),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ok              (out_ok),
    .out_frame_index     (out_frame_index),
    .out_allocated_total (out_allocated_total),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_count(input int short_max, input int mid_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(0, 8191);
    if (r < 75) return $urandom_range(1, short_max);
    return $urandom_range(short_max + 1, mid_max);
  endfunction

  task automatic send_op(input logic kind, input int first, input int count);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_kind = kind;
    in_start_frame = first[11:0];
    in_frame_count = count[12:0];
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_words(input int n);
    drain();
    repeat (4) @(negedge clk);
    while (in_stall) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = n[6:0];
    cur_words = n;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // frees keep clear of frame zero: once freed it can never be taken again
  task automatic send_random();
    int span;
    int first;
    span = (cur_words > FRAME_WORDS ? FRAME_WORDS : cur_words) * WORD_BITS;
    if ($urandom_range(0, 99) < 45) begin
      if (span < 2 || $urandom_range(0, 9) == 0) first = $urandom_range(1, 4095);
      else first = $urandom_range(1, span - 1);
      send_op(KIND_FREE, first, pick_count(64, 1000));
    end else begin
      send_op(KIND_ALLOC, $urandom_range(0, 4095), pick_count(48, 400));
    end
  endtask

  initial begin : out_side
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
        left = 0;
      end else begin
        if (left == 0) left = pick_gap();
        out_stall = (left > 0);
        if (left > 0) left--;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb_bitmap_frame_allocator: errors");
    $finish;
  end

  initial begin : stimulus
    int phase_words [8];
    phase_words = '{64, 2, 127, 33, 0, 1, 100, 64};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // map starts fully used, so the allocations before the first free all miss
    send_op(KIND_ALLOC, 0, 0);
    send_op(KIND_ALLOC, 4095, 1);
    send_op(KIND_FREE, 0, 0);
    send_op(KIND_FREE, 1, 4095);
    send_op(KIND_ALLOC, 0, 4096);
    send_op(KIND_ALLOC, 0, 8191);
    send_op(KIND_ALLOC, 0, 4095);
    send_op(KIND_ALLOC, 0, 1);
    send_op(KIND_FREE, 4095, 8191);
    send_op(KIND_ALLOC, 0, 1);
    send_op(KIND_FREE, 64, 64);
    send_op(KIND_ALLOC, 0, 64);
    // two adjacent pieces that join into one run across a word boundary
    send_op(KIND_FREE, 100, 30);
    send_op(KIND_FREE, 130, 20);
    send_op(KIND_ALLOC, 0, 50);
    send_op(KIND_FREE, 63, 2);
    send_op(KIND_ALLOC, 0, 2);
    write_words(1);
    send_op(KIND_FREE, 1, 200);
    send_op(KIND_ALLOC, 0, 64);
    send_op(KIND_ALLOC, 0, 63);
    write_words(0);
    send_op(KIND_FREE, 1, 10);
    send_op(KIND_ALLOC, 0, 1);
    write_words(127);
    send_op(KIND_FREE, 2000, 3000);
    send_op(KIND_ALLOC, 0, 2000);

    phase_words[3] = $urandom_range(3, 63);
    foreach (phase_words[p]) begin
      write_words(phase_words[p]);
      calm = (p == 3);
      if (p == 6) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      repeat (45) send_random();
    end

    // frame zero free: any run that would start there reads as null
    calm = 1'b0;
    write_words(64);
    send_op(KIND_FREE, 0, 1);
    send_op(KIND_ALLOC, 0, 1);
    send_op(KIND_FREE, 0, 3);
    send_op(KIND_ALLOC, 0, 2);
    send_op(KIND_ALLOC, 0, 3);
    repeat (10) send_random();

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_bitmap_frame_allocator: clean");
    end else begin
      $display("tb_bitmap_frame_allocator: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bfa_pkg.sv
rtl/bfa_ram.sv
rtl/bfa_word_eval.sv
rtl/bitmap_frame_allocator.sv
tb/bfa_frame_checker.sv
tb/tb_bitmap_frame_allocator.sv
